// ===== design/azel_pkg.sv =====
`timescale 1ns / 1ps

package azel_pkg;

    localparam int unsigned NUM_ZONES = 4;
    localparam int unsigned MSG_LEN   = 18;
    localparam int unsigned IDX_W     = $clog2(MSG_LEN);

    localparam logic [2:0] REG_TONE_ONE   = 3'd0;
    localparam logic [2:0] REG_TONE_TWO   = 3'd1;
    localparam logic [2:0] REG_TONE_THREE = 3'd2;
    localparam logic [2:0] REG_TONE_FOUR  = 3'd3;
    localparam logic [2:0] REG_ALARM_SECS = 3'd4;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_LEN - 1);

    typedef struct packed {
        logic       req_type;
        logic [3:0] zones;
    } t_in_item;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_code;
        logic       last;
        logic [7:0] buzzer_period;
    } t_out_item;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
    } t_time;

    typedef struct packed {
        logic       is_msg;
        logic [1:0] zone;
        t_time      stamp;
        logic [7:0] tone;
    } t_job;

endpackage

// ===== design/alarm_zone_event_logger.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// state is updated in the cycle an item is accepted; results leave from the
// message register one per cycle while the output is ready
// a tick or a sample with no alarm gives one result, an alarm 18, so the
// input takes one item per cycle while the output is ready, none mid-message
// a stalled output holds the message register and the input waits behind it
// synchronous active-low reset restores the time, zones, buzzer and registers

module alarm_zone_event_logger
    import azel_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic accept;
    logic free;
    t_job job;

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    azel_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .o_job      (job)
    );

    azel_msg u_msg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_job       (job),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/azel_core.sv =====
`timescale 1ns / 1ps

module azel_core
    import azel_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_accept,
    input  t_in_item   i_item,
    output t_job       o_job
);

    logic [7:0] r_tone_zone [NUM_ZONES];
    logic [3:0] r_alarm_seconds;

    t_time      r_time,        n_time;
    logic [3:0] r_reported,    n_reported;
    logic [4:0] r_buzz_left,   n_buzz_left;
    logic [7:0] r_active_tone, n_active_tone;

    t_time      adv;
    logic [3:0] armed;
    logic [3:0] fresh;
    logic [1:0] zone;

    always_comb begin
        adv = r_time;
        if (r_time.second_units < 4'd9) begin
            adv.second_units = r_time.second_units + 4'd1;
        end else begin
            adv.second_units = '0;
            if (r_time.second_tens < 3'd5) begin
                adv.second_tens = r_time.second_tens + 3'd1;
            end else begin
                adv.second_tens = '0;
                if (r_time.minute_units < 4'd9) begin
                    adv.minute_units = r_time.minute_units + 4'd1;
                end else begin
                    adv.minute_units = '0;
                    if (r_time.minute_tens < 3'd5) begin
                        adv.minute_tens = r_time.minute_tens + 3'd1;
                    end else begin
                        adv.minute_tens = '0;
                        if (r_time.hour_tens >= 2'd2 && r_time.hour_units >= 4'd3) begin
                            adv.hour_tens  = '0;
                            adv.hour_units = '0;
                        end else if (r_time.hour_units < 4'd9) begin
                            adv.hour_units = r_time.hour_units + 4'd1;
                        end else begin
                            adv.hour_units = '0;
                            adv.hour_tens  = r_time.hour_tens + 2'd1;
                        end
                    end
                end
            end
        end
    end

    assign armed = r_reported & i_item.zones;
    assign fresh = i_item.zones & ~armed;

    always_comb begin
        priority if (fresh[0]) begin
            zone = 2'd0;
        end else if (fresh[1]) begin
            zone = 2'd1;
        end else if (fresh[2]) begin
            zone = 2'd2;
        end else begin
            zone = 2'd3;
        end
    end

    always_comb begin
        n_time        = r_time;
        n_reported    = r_reported;
        n_buzz_left   = r_buzz_left;
        n_active_tone = r_active_tone;
        o_job.is_msg  = 1'b0;
        o_job.zone    = zone;
        o_job.stamp   = r_time;
        if (i_item.req_type == REQ_TICK) begin
            n_time = adv;
            if (r_buzz_left != '0) begin
                n_buzz_left = r_buzz_left - 5'd1;
                if (r_buzz_left == 5'd1) begin
                    n_active_tone = '0;
                end
            end
        end else if (r_buzz_left == '0) begin
            n_reported = armed;
            if (fresh != '0) begin
                n_reported    = armed | (4'd1 << zone);
                n_active_tone = r_tone_zone[zone];
                n_buzz_left   = {1'b0, r_alarm_seconds} + 5'd1;
                o_job.is_msg  = 1'b1;
            end
        end
        o_job.tone = n_active_tone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_zone[0]  <= 8'd100;
            r_tone_zone[1]  <= 8'd120;
            r_tone_zone[2]  <= 8'd140;
            r_tone_zone[3]  <= 8'd160;
            r_alarm_seconds <= 4'd3;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_TONE_ONE) begin
                r_tone_zone[0] <= i_cfg_data;
            end
            if (i_cfg_idx == REG_TONE_TWO) begin
                r_tone_zone[1] <= i_cfg_data;
            end
            if (i_cfg_idx == REG_TONE_THREE) begin
                r_tone_zone[2] <= i_cfg_data;
            end
            if (i_cfg_idx == REG_TONE_FOUR) begin
                r_tone_zone[3] <= i_cfg_data;
            end
            if (i_cfg_idx == REG_ALARM_SECS) begin
                r_alarm_seconds <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time        <= '0;
            r_reported    <= '0;
            r_buzz_left   <= '0;
            r_active_tone <= '0;
        end else if (i_accept) begin
            r_time        <= n_time;
            r_reported    <= n_reported;
            r_buzz_left   <= n_buzz_left;
            r_active_tone <= n_active_tone;
        end
    end

endmodule

// ===== design/azel_msg.sv =====
`timescale 1ns / 1ps

module azel_msg
    import azel_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_job      i_job,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_idx,  n_idx;
    t_job             r_job;

    logic       done;
    logic       step;
    logic [7:0] code;

    assign step   = r_busy && i_out_ready;
    assign done   = step && (!r_job.is_msg || r_idx == LAST_IDX);
    assign o_free = !r_busy || done;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (step) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    // message characters
    always_comb begin
        unique case (r_idx)
            5'd0:    code = "z";
            5'd1:    code = "o";
            5'd2:    code = "n";
            5'd3:    code = "a";
            5'd4:    code = ":";
            5'd5:    code = 8'h31 + {6'd0, r_job.zone};
            5'd6:    code = "_";
            5'd7:    code = "(";
            5'd8:    code = 8'h30 + {6'd0, r_job.stamp.hour_tens};
            5'd9:    code = 8'h30 + {4'd0, r_job.stamp.hour_units};
            5'd10:   code = ":";
            5'd11:   code = 8'h30 + {5'd0, r_job.stamp.minute_tens};
            5'd12:   code = 8'h30 + {4'd0, r_job.stamp.minute_units};
            5'd13:   code = ":";
            5'd14:   code = 8'h30 + {5'd0, r_job.stamp.second_tens};
            5'd15:   code = 8'h30 + {4'd0, r_job.stamp.second_units};
            5'd16:   code = ")";
            5'd17:   code = 8'h0a;
            default: code = '0;
        endcase
    end

    assign o_out_valid              = r_busy;
    assign o_out_data.char_valid    = r_job.is_msg;
    assign o_out_data.char_code     = r_job.is_msg ? code : 8'd0;
    assign o_out_data.last          = !r_job.is_msg || r_idx == LAST_IDX;
    assign o_out_data.buzzer_period = r_job.tone;

endmodule

// ===== tb/sv/panel_event_checker.sv =====
`timescale 1ns / 1ps

module panel_event_checker
    import azel_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_alarm_count,
    output int         o_result_count
);

    t_time      clock_now;
    logic [3:0] zones_reported;
    logic [4:0] buzz_left;
    logic [7:0] tone_now;
    logic [7:0] tone_reg [NUM_ZONES];
    logic [3:0] alarm_secs;
    t_out_item  results_due [$];
    int         fails;
    int         alarms;
    int         results_seen;

    function automatic t_time next_second(input t_time t);
        t_time n;
        n = t;
        if (t.second_units < 4'd9) begin
            n.second_units = t.second_units + 4'd1;
        end else begin
            n.second_units = '0;
            if (t.second_tens < 3'd5) begin
                n.second_tens = t.second_tens + 3'd1;
            end else begin
                n.second_tens = '0;
                if (t.minute_units < 4'd9) begin
                    n.minute_units = t.minute_units + 4'd1;
                end else begin
                    n.minute_units = '0;
                    if (t.minute_tens < 3'd5) begin
                        n.minute_tens = t.minute_tens + 3'd1;
                    end else begin
                        n.minute_tens = '0;
                        if (t.hour_tens >= 2'd2 && t.hour_units >= 4'd3) begin
                            n.hour_tens  = '0;
                            n.hour_units = '0;
                        end else if (t.hour_units < 4'd9) begin
                            n.hour_units = t.hour_units + 4'd1;
                        end else begin
                            n.hour_units = '0;
                            n.hour_tens  = t.hour_tens + 2'd1;
                        end
                    end
                end
            end
        end
        return n;
    endfunction

    task automatic reset_panel();
        tone_reg[0]    = 8'd100;
        tone_reg[1]    = 8'd120;
        tone_reg[2]    = 8'd140;
        tone_reg[3]    = 8'd160;
        alarm_secs     = 4'd3;
        clock_now      = '0;
        zones_reported = '0;
        buzz_left      = '0;
        tone_now       = '0;
        results_due.delete();
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
        case (idx)
            REG_TONE_ONE:   tone_reg[0] = data;
            REG_TONE_TWO:   tone_reg[1] = data;
            REG_TONE_THREE: tone_reg[2] = data;
            REG_TONE_FOUR:  tone_reg[3] = data;
            REG_ALARM_SECS: alarm_secs = data[3:0];
            default: ;
        endcase
    endtask

    task automatic queue_result(input logic valid, input logic [7:0] code, input logic fin);
        t_out_item r;
        r.char_valid    = valid;
        r.char_code     = code;
        r.last          = fin;
        r.buzzer_period = tone_now;
        results_due.push_back(r);
    endtask

    task automatic panel_step(input t_in_item item);
        logic [3:0] fresh;
        int         z;
        int         i;
        logic [7:0] text [MSG_LEN];
        if (item.req_type == REQ_TICK) begin
            clock_now = next_second(clock_now);
            if (buzz_left != 0) begin
                buzz_left = buzz_left - 5'd1;
                if (buzz_left == 0)
                    tone_now = '0;
            end
            queue_result(1'b0, 8'd0, 1'b1);
        end else if (buzz_left != 0) begin
            queue_result(1'b0, 8'd0, 1'b1);
        end else begin
            zones_reported = zones_reported & item.zones;
            fresh = item.zones & ~zones_reported;
            if (fresh == 0) begin
                queue_result(1'b0, 8'd0, 1'b1);
            end else begin
                z = 0;
                while (z < 3 && !fresh[z])
                    z++;
                zones_reported[z] = 1'b1;
                tone_now  = tone_reg[z];
                buzz_left = 5'(alarm_secs) + 5'd1;
                alarms++;
                text[0]  = "z";
                text[1]  = "o";
                text[2]  = "n";
                text[3]  = "a";
                text[4]  = ":";
                text[5]  = "1" + 8'(z);
                text[6]  = "_";
                text[7]  = "(";
                text[8]  = "0" + 8'(clock_now.hour_tens);
                text[9]  = "0" + 8'(clock_now.hour_units);
                text[10] = ":";
                text[11] = "0" + 8'(clock_now.minute_tens);
                text[12] = "0" + 8'(clock_now.minute_units);
                text[13] = ":";
                text[14] = "0" + 8'(clock_now.second_tens);
                text[15] = "0" + 8'(clock_now.second_units);
                text[16] = ")";
                text[17] = "\n";
                for (i = 0; i < MSG_LEN; i++)
                    queue_result(1'b1, text[i], i == MSG_LEN - 1);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item seen;
        t_out_item want;
        if (!i_rst_n) begin
            reset_panel();
        end else begin
            if (i_cfg_we)
                write_register(i_cfg_idx, i_cfg_data);
            if (i_in_valid && i_in_ready)
                panel_step(i_in_data);
            if (i_out_valid && i_out_ready) begin
                seen = i_out_data;
                results_seen++;
                if (results_due.size() == 0) begin
                    $error("result %0h arrived with nothing expected", seen);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    check_field("char_valid", 8'(want.char_valid), 8'(seen.char_valid));
                    check_field("char_code", want.char_code, seen.char_code);
                    check_field("last", 8'(want.last), 8'(seen.last));
                    check_field("buzzer_period", want.buzzer_period, seen.buzzer_period);
                end
            end
        end
        o_pending      <= results_due.size();
        o_fail_count   <= fails;
        o_alarm_count  <= alarms;
        o_result_count <= results_seen;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import azel_pkg::*;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_idx   = '0;
    logic [7:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int alarm_count;
    int result_count;

    bit tx_idling      = 1'b1;
    bit rx_idling      = 1'b1;
    int rx_hold_len    = 0;
    int items_sent     = 0;
    int reg_writes     = 0;
    int alarm_secs_now = 3;

    alarm_zone_event_logger dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    panel_event_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_alarm_count  (alarm_count),
        .o_result_count (result_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #24_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver side: random stalls, plus a long hold when asked
    initial begin
        forever begin
            @(negedge clk);
            if (rx_hold_len > 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold_len - 1) @(negedge clk);
                rx_hold_len = 0;
            end else if (rx_idling && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat (gap_len() - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic offer(input logic req, input logic [3:0] zones);
        t_in_item item;
        int       gap;
        item.req_type = req;
        item.zones    = zones;
        gap = (tx_idling && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        reg_writes++;
        if (idx == REG_ALARM_SECS)
            alarm_secs_now = data[3:0];
    endtask

    // sample/tick episodes, ticks sometimes too few to end the buzzer
    task automatic run_traffic(input int count);
        int         done;
        int         ticks;
        logic [3:0] z;
        done = 0;
        while (done < count) begin
            z = ($urandom_range(0, 3) == 0) ? 4'b0000 : 4'($urandom);
            offer(REQ_SAMPLE, z);
            ticks = $urandom_range(0, alarm_secs_now + 3);
            repeat (ticks) offer(REQ_TICK, 4'($urandom));
            done += 1 + ticks;
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer(REQ_SAMPLE, 4'b0000);
        offer(REQ_SAMPLE, 4'b1111);
        offer(REQ_SAMPLE, 4'b1111);
        repeat (4) offer(REQ_TICK, 4'b0000);
        offer(REQ_SAMPLE, 4'b1111);
        repeat (4) offer(REQ_TICK, 4'b1111);
        offer(REQ_SAMPLE, 4'b1110);
        repeat (4) offer(REQ_TICK, 4'b0101);
        offer(REQ_SAMPLE, 4'b1000);
        repeat (4) offer(REQ_TICK, 4'b1010);
        offer(REQ_SAMPLE, 4'b1000);
        offer(REQ_SAMPLE, 4'b0001);

        tx_idling = 1'b0;
        rx_idling = 1'b0;

        settle();
        write_reg(REG_TONE_ONE, 8'd0);
        write_reg(REG_TONE_TWO, 8'd255);
        write_reg(REG_TONE_THREE, 8'd1);
        write_reg(REG_TONE_FOUR, 8'hAA);
        write_reg(REG_ALARM_SECS, 8'd0);
        write_reg(3'd5, 8'h55);
        write_reg(3'd6, 8'hFF);
        write_reg(3'd7, 8'h0F);
        rx_hold_len = 250;
        run_traffic(20);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        run_traffic(70);

        settle();
        write_reg(REG_TONE_ONE, 8'($urandom));
        write_reg(REG_TONE_TWO, 8'($urandom));
        write_reg(REG_TONE_THREE, 8'd0);
        write_reg(REG_TONE_FOUR, 8'd255);
        write_reg(REG_ALARM_SECS, 8'hFF);
        run_traffic(100);

        settle();
        write_reg(REG_TONE_ONE, 8'd255);
        write_reg(REG_TONE_TWO, 8'd1);
        write_reg(REG_TONE_THREE, 8'($urandom));
        write_reg(REG_TONE_FOUR, 8'd0);
        write_reg(REG_ALARM_SECS, {4'($urandom), 4'($urandom_range(1, 14))});
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_traffic(45);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        run_traffic(45);

        settle();
        repeat (20) @(negedge clk);
        $display("covered %0d items: zone priority and re-arm cases, %0d reg writes",
                 items_sent, reg_writes);
        $display("%0d alarm messages and %0d results compared", alarm_count, result_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/azel_pkg.sv
design/azel_core.sv
design/azel_msg.sv
design/alarm_zone_event_logger.sv
tb/sv/panel_event_checker.sv
tb/sv/tb.sv
